// ----- design/aera_pkg.sv -----
// Package with payload types, table entry types and codes of the extent range allocator.
`timescale 1ns / 1ps
package aera_pkg;

  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StInvalid   = 3'd1;
  localparam logic [2:0] StNoSpace   = 3'd2;
  localparam logic [2:0] StTableFull = 3'd3;
  localparam logic [2:0] StIdsOut    = 3'd4;
  localparam logic [2:0] StCorrupt   = 3'd5;

  localparam logic OpReserve = 1'b0;
  localparam logic OpRelease = 1'b1;

  localparam logic [1:0] CfgManagedBase  = 2'd0;
  localparam logic [1:0] CfgManagedPages = 2'd1;

  typedef struct packed {
    logic        op;
    logic [51:0] span_pages;
    logic [5:0]  align_log2;
    logic        prefer_high;
    logic [51:0] release_base_page;
    logic [63:0] release_id;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [51:0] base_page;
    logic [63:0] grant_id;
    logic [51:0] free_pages;
    logic [51:0] reserved_pages;
    logic [6:0]  free_extents;
    logic [6:0]  active_reservations;
  } rsp_t;

  typedef struct packed {
    logic [52:0] base;
    logic [51:0] pages;
  } ext_t;

  typedef struct packed {
    logic [63:0] id;
    logic [52:0] base;
    logic [51:0] pages;
  } rec_t;

endpackage

// ----- design/aera_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module aera_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/aligned_extent_range_allocator_core.sv -----
// Top level of the aligned extent range allocator with its request sequencer.
`timescale 1ns / 1ps
// The block keeps a sorted table of free page extents and a table of active
// reservations, both in on-chip RAMs, and serves one item at a time through
// a sequencer that reuses one read port, one write port and one compare path
// per table. A reserve scans the extents for one that fits, scans the
// reservation slots for a free one and moves extent entries on a split or
// when an extent is used up. A release scans the slots for its id, passes
// extents to find its place and moves entries when it inserts a new extent
// or merges two. A failed check ends the item early. After reset and after
// every write to the managed base or pages register the reservation table
// is cleared, during which no item is accepted. A result waits in an output
// register while the next item is already taken in.
module aligned_extent_range_allocator_core
  import aera_pkg::*;
#(
  parameter int RESERVATION_SLOTS = 64,
  parameter int PAGE_SHIFT = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  req_t        in_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output rsp_t        out_rsp_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [51:0] cfg_data_i
);

  localparam int ExtSlots = RESERVATION_SLOTS + 1;
  localparam int EAW = $clog2(ExtSlots);
  localparam int EUW = $clog2(ExtSlots + 1);
  localparam int RAW = (RESERVATION_SLOTS > 1) ? $clog2(RESERVATION_SLOTS) : 1;
  localparam int RUW = $clog2(RESERVATION_SLOTS + 1);
  localparam int FitShift = 64 - PAGE_SHIFT;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_CHECK, S_XRD, S_XEV, S_XCK, S_RRD, S_RCK,
    S_PRD, S_PCK, S_DECIDE, S_W1, S_SHRD, S_SHWR, S_FIN, S_OUT
  } state_e;

  typedef enum logic [1:0] {ShNone, ShIns, ShRem} shift_e;

  state_e         state_q;
  shift_e         sh_q;
  req_t           req_q;
  rsp_t           out_q;
  logic           out_valid_q;
  logic [51:0]    mbase_q, mpages_q, free_q, resv_q;
  logic           ready_q;
  logic [EUW-1:0] used_q, i_q, j_q, idx_q, sh_pos_q;
  logic [RUW-1:0] active_q, s_q;
  logic [63:0]    next_id_q, id_out_q, c_q, mask_q;
  logic [52:0]    b_q, end_q, base_out_q;
  logic           fit_q, has_next_q, w1_en_q;
  logic [2:0]     st_q;
  logic [RAW-1:0] slot_q;
  logic [EAW-1:0] w1_addr_q;
  ext_t           w1_data_q, ins_q, prev_q, next_q;

  logic           ext_we;
  logic [EAW-1:0] ext_waddr, ext_raddr;
  ext_t           ext_wdata, ext_rdata;
  logic           rec_we;
  logic [RAW-1:0] rec_waddr, rec_raddr;
  rec_t           rec_wdata, rec_rdata;

  logic           cfg_fire;
  logic [51:0]    new_base, new_pages;
  logic [52:0]    new_end;
  logic           new_ready;
  logic [EUW-1:0] k_w;
  logic [52:0]    cnt53, rb53, rend, mend, c53, pre, suf, pend, ev_end;
  logic [63:0]    ev_c_lo, ck_c_hi;
  logic           found, split, ov_p, ov_n, mp, mn, over, has_prev;
  logic           fits_cnt, align_bad, rel_bad;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire = cfg_valid_i &&
                    (cfg_index_i == CfgManagedBase || cfg_index_i == CfgManagedPages);
  assign new_base  = (cfg_index_i == CfgManagedBase) ? cfg_data_i : mbase_q;
  assign new_pages = (cfg_index_i == CfgManagedPages) ? cfg_data_i : mpages_q;
  assign new_end   = {1'b0, new_base} + {1'b0, new_pages};
  assign new_ready = (new_pages != '0) && ((64'(new_end) >> FitShift) == 64'd0);

  assign in_stall_o  = (state_q != S_IDLE) || cfg_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  always_comb begin
    k_w = req_q.prefer_high ? (used_q - EUW'(1) - i_q) : i_q;
    cnt53 = {1'b0, req_q.span_pages};
    rb53  = {1'b0, req_q.release_base_page};
    rend  = rb53 + cnt53;
    mend  = {1'b0, mbase_q} + {1'b0, mpages_q};
    fits_cnt  = (64'(req_q.span_pages) >> FitShift) == 64'd0;
    align_bad = (int'(req_q.align_log2) + PAGE_SHIFT) > 63;
    rel_bad   = !ready_q || req_q.release_id == '0 || req_q.span_pages == '0 ||
                !fits_cnt || rb53 < {1'b0, mbase_q} || rend > mend ||
                resv_q < req_q.span_pages;
    ev_end  = ext_rdata.base + 53'(ext_rdata.pages);
    ev_c_lo = (64'(ext_rdata.base) + mask_q) & ~mask_q;
    ck_c_hi = 64'(end_q - cnt53) & ~mask_q;
    if (req_q.prefer_high) begin
      found = fit_q && (ck_c_hi >= 64'(b_q));
    end else begin
      found = fit_q && (c_q <= 64'(end_q)) && (64'(cnt53) <= (64'(end_q) - c_q));
    end
    c53   = c_q[52:0];
    pre   = c53 - b_q;
    suf   = end_q - (c53 + cnt53);
    split = (pre != '0) && (suf != '0);
    has_prev = i_q != '0;
    pend  = prev_q.base + 53'(prev_q.pages);
    ov_p  = has_prev && rb53 < pend;
    ov_n  = has_next_q && rend > next_q.base;
    mp    = has_prev && pend == rb53;
    mn    = has_next_q && rend == next_q.base;
    over  = ({1'b0, free_q} + cnt53) > {1'b0, mpages_q};
  end

  always_comb begin
    ext_raddr = i_q[EAW-1:0];
    unique case (state_q)
      S_XRD:   ext_raddr = k_w[EAW-1:0];
      S_SHRD:  ext_raddr = (sh_q == ShIns) ? EAW'(j_q - EUW'(1)) : j_q[EAW-1:0];
      default: ext_raddr = i_q[EAW-1:0];
    endcase
    ext_we    = 1'b0;
    ext_waddr = w1_addr_q;
    ext_wdata = w1_data_q;
    if (cfg_fire) begin
      ext_we    = 1'b1;
      ext_waddr = '0;
      ext_wdata = '{base: {1'b0, new_base}, pages: new_pages};
    end else if (state_q == S_W1) begin
      ext_we = w1_en_q;
    end else if (state_q == S_SHWR) begin
      ext_we    = 1'b1;
      ext_waddr = (sh_q == ShIns) ? j_q[EAW-1:0] : EAW'(j_q - EUW'(1));
      ext_wdata = ext_rdata;
    end else if (state_q == S_FIN && sh_q == ShIns) begin
      ext_we    = 1'b1;
      ext_waddr = sh_pos_q[EAW-1:0];
      ext_wdata = ins_q;
    end
    rec_raddr = s_q[RAW-1:0];
    rec_we    = 1'b0;
    rec_waddr = slot_q;
    rec_wdata = '0;
    if (state_q == S_CLEAR) begin
      rec_we    = 1'b1;
      rec_waddr = s_q[RAW-1:0];
    end else if (state_q == S_FIN) begin
      rec_we = 1'b1;
      if (req_q.op == OpReserve) begin
        rec_wdata = '{id: id_out_q, base: base_out_q, pages: req_q.span_pages};
      end
    end
  end

  aera_ram #(.WIDTH($bits(ext_t)), .DEPTH(ExtSlots)) u_ext_ram (
    .clk_i   (clk_i),
    .we_i    (ext_we),
    .waddr_i (ext_waddr),
    .wdata_i (ext_wdata),
    .raddr_i (ext_raddr),
    .rdata_o (ext_rdata)
  );

  aera_ram #(.WIDTH($bits(rec_t)), .DEPTH(RESERVATION_SLOTS)) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (rec_waddr),
    .wdata_i (rec_wdata),
    .raddr_i (rec_raddr),
    .rdata_o (rec_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      s_q         <= '0;
      out_valid_q <= 1'b0;
      mbase_q     <= '0;
      mpages_q    <= '0;
      ready_q     <= 1'b0;
      used_q      <= '0;
      active_q    <= '0;
      next_id_q   <= 64'd1;
      free_q      <= '0;
      resv_q      <= '0;
      sh_q        <= ShNone;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_fire) begin
        mbase_q   <= new_base;
        mpages_q  <= new_pages;
        ready_q   <= new_ready;
        used_q    <= new_ready ? EUW'(1) : '0;
        free_q    <= new_ready ? new_pages : '0;
        resv_q    <= '0;
        active_q  <= '0;
        next_id_q <= 64'd1;
        s_q       <= '0;
        state_q   <= S_CLEAR;
      end else begin
        unique case (state_q)
          S_IDLE: begin
            if (in_valid_i && !in_stall_o) begin
              req_q   <= in_req_i;
              state_q <= S_CHECK;
            end
          end
          S_CLEAR: begin
            s_q <= s_q + RUW'(1);
            if (s_q == RUW'(RESERVATION_SLOTS - 1)) begin
              state_q <= S_IDLE;
            end
          end
          S_CHECK: begin
            i_q        <= '0;
            s_q        <= '0;
            has_next_q <= 1'b0;
            base_out_q <= '0;
            id_out_q   <= '0;
            mask_q     <= (64'd1 << req_q.align_log2) - 64'd1;
            if (req_q.op == OpReserve) begin
              if (!ready_q) begin
                st_q    <= StCorrupt;
                state_q <= S_OUT;
              end else if (req_q.span_pages == '0 || !fits_cnt || align_bad) begin
                st_q    <= StInvalid;
                state_q <= S_OUT;
              end else begin
                state_q <= S_XRD;
              end
            end else if (rel_bad) begin
              st_q    <= StCorrupt;
              state_q <= S_OUT;
            end else begin
              state_q <= S_RRD;
            end
          end
          S_XRD: begin
            if (i_q >= used_q) begin
              st_q    <= StNoSpace;
              state_q <= S_OUT;
            end else begin
              state_q <= S_XEV;
            end
          end
          S_XEV: begin
            b_q     <= ext_rdata.base;
            end_q   <= ev_end;
            c_q     <= ev_c_lo;
            fit_q   <= req_q.span_pages <= ext_rdata.pages;
            idx_q   <= k_w;
            state_q <= S_XCK;
          end
          S_XCK: begin
            if (found) begin
              if (req_q.prefer_high) begin
                c_q <= ck_c_hi;
              end
              if (free_q < req_q.span_pages) begin
                st_q    <= StCorrupt;
                state_q <= S_OUT;
              end else begin
                state_q <= S_RRD;
              end
            end else begin
              i_q     <= i_q + EUW'(1);
              state_q <= S_XRD;
            end
          end
          S_RRD: begin
            if (s_q == RUW'(RESERVATION_SLOTS)) begin
              st_q    <= (req_q.op == OpReserve) ? StTableFull : StCorrupt;
              state_q <= S_OUT;
            end else begin
              state_q <= S_RCK;
            end
          end
          S_RCK: begin
            if (req_q.op == OpReserve && rec_rdata.id == '0) begin
              slot_q  <= s_q[RAW-1:0];
              state_q <= S_DECIDE;
            end else if (req_q.op == OpRelease && rec_rdata.id == req_q.release_id) begin
              slot_q <= s_q[RAW-1:0];
              if (rec_rdata.base != rb53 || rec_rdata.pages != req_q.span_pages) begin
                st_q    <= StCorrupt;
                state_q <= S_OUT;
              end else begin
                state_q <= S_PRD;
              end
            end else begin
              s_q     <= s_q + RUW'(1);
              state_q <= S_RRD;
            end
          end
          S_PRD: begin
            state_q <= (i_q == used_q) ? S_DECIDE : S_PCK;
          end
          S_PCK: begin
            if (ext_rdata.base < rb53) begin
              prev_q  <= ext_rdata;
              i_q     <= i_q + EUW'(1);
              state_q <= S_PRD;
            end else begin
              next_q     <= ext_rdata;
              has_next_q <= 1'b1;
              state_q    <= S_DECIDE;
            end
          end
          S_DECIDE: begin
            state_q <= S_W1;
            w1_en_q <= 1'b1;
            sh_q    <= ShNone;
            if (req_q.op == OpReserve) begin
              w1_addr_q <= idx_q[EAW-1:0];
              sh_pos_q  <= idx_q;
              if (split && used_q >= EUW'(ExtSlots)) begin
                st_q    <= StTableFull;
                state_q <= S_OUT;
              end else if (next_id_q == '0) begin
                st_q    <= StIdsOut;
                state_q <= S_OUT;
              end else begin
                id_out_q   <= next_id_q;
                base_out_q <= c53;
                if (split) begin
                  w1_data_q <= '{base: b_q, pages: pre[51:0]};
                  sh_q      <= ShIns;
                  sh_pos_q  <= idx_q + EUW'(1);
                  ins_q     <= '{base: c53 + cnt53, pages: suf[51:0]};
                end else if (pre != '0) begin
                  w1_data_q <= '{base: b_q, pages: pre[51:0]};
                end else if (suf != '0) begin
                  w1_data_q <= '{base: c53 + cnt53, pages: suf[51:0]};
                end else begin
                  w1_en_q <= 1'b0;
                  sh_q    <= ShRem;
                end
              end
            end else begin
              sh_pos_q <= i_q;
              if (ov_p || ov_n || over) begin
                st_q    <= StCorrupt;
                state_q <= S_OUT;
              end else if (!mp && !mn && used_q >= EUW'(ExtSlots)) begin
                st_q    <= StTableFull;
                state_q <= S_OUT;
              end else if (mp) begin
                w1_addr_q <= EAW'(i_q - EUW'(1));
                if (mn) begin
                  w1_data_q <= '{base: prev_q.base,
                                 pages: prev_q.pages + req_q.span_pages + next_q.pages};
                  sh_q      <= ShRem;
                end else begin
                  w1_data_q <= '{base: prev_q.base, pages: prev_q.pages + req_q.span_pages};
                end
              end else if (mn) begin
                w1_addr_q <= i_q[EAW-1:0];
                w1_data_q <= '{base: rb53, pages: next_q.pages + req_q.span_pages};
              end else begin
                w1_en_q <= 1'b0;
                sh_q    <= ShIns;
                ins_q   <= '{base: rb53, pages: req_q.span_pages};
              end
            end
          end
          S_W1: begin
            j_q     <= (sh_q == ShIns) ? used_q : sh_pos_q + EUW'(1);
            state_q <= (sh_q == ShNone) ? S_FIN : S_SHRD;
          end
          S_SHRD: begin
            if (sh_q == ShIns) begin
              state_q <= (j_q == sh_pos_q) ? S_FIN : S_SHWR;
            end else begin
              state_q <= (j_q >= used_q) ? S_FIN : S_SHWR;
            end
          end
          S_SHWR: begin
            j_q     <= (sh_q == ShIns) ? j_q - EUW'(1) : j_q + EUW'(1);
            state_q <= S_SHRD;
          end
          S_FIN: begin
            if (sh_q == ShIns) begin
              used_q <= used_q + EUW'(1);
            end else if (sh_q == ShRem) begin
              used_q <= used_q - EUW'(1);
            end
            if (req_q.op == OpReserve) begin
              free_q    <= free_q - req_q.span_pages;
              resv_q    <= resv_q + req_q.span_pages;
              active_q  <= active_q + RUW'(1);
              next_id_q <= next_id_q + 64'd1;
            end else begin
              free_q   <= free_q + req_q.span_pages;
              resv_q   <= resv_q - req_q.span_pages;
              active_q <= active_q - RUW'(1);
            end
            st_q    <= StOk;
            state_q <= S_OUT;
          end
          S_OUT: begin
            if (!out_valid_q || !out_stall_i) begin
              out_q <= '{status: st_q,
                         base_page: base_out_q[51:0],
                         grant_id: id_out_q,
                         free_pages: free_q,
                         reserved_pages: resv_q,
                         free_extents: 7'(used_q),
                         active_reservations: 7'(active_q)};
              out_valid_q <= 1'b1;
              state_q     <= S_IDLE;
            end
          end
          default: state_q <= S_IDLE;
        endcase
      end
    end
  end

endmodule
